// ----- src/sign_magnitude_accumulator_alu_unit_defines.svh -----
// assertion helpers for the accumulator alu
`ifndef SIGN_MAGNITUDE_ACCUMULATOR_ALU_UNIT_DEFINES_SVH
`define SIGN_MAGNITUDE_ACCUMULATOR_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define SMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sma assertion failed");

// next-cycle implication
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sma assertion failed");

`endif

// ----- src/sma_pkg.sv -----
package sma_pkg;

  localparam int unsigned AddrWidthDef = 7;
  localparam int unsigned KindW        = 7;
  localparam int unsigned WordW        = 15;
  localparam int unsigned MagW         = 14;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CntW         = $clog2(MagW + 1);

  localparam logic [KindW-1:0] KIND_ADD = 7'h30;
  localparam logic [KindW-1:0] KIND_SUB = 7'h31;
  localparam logic [KindW-1:0] KIND_DIV = 7'h32;
  localparam logic [KindW-1:0] KIND_MUL = 7'h33;
  localparam logic [KindW-1:0] KIND_SHL = 7'h67;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_DIV,
    OP_MUL,
    OP_SHL,
    OP_BAD
  } sma_op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_OVF   = 2'd1,
    STAT_BADOP = 2'd2,
    STAT_DIV0  = 2'd3
  } sma_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } sma_state_e;

endpackage

// ----- src/sign_magnitude_accumulator_alu_unit.sv -----
// add, sub, bad opcode, divide by zero and shifts of a zero word or by 14 or more
//   go from input accept straight to the done state; the serial ops run a
//   one-bit-per-cycle shift-add / restoring-divide / shift loop on a 4-bit step
//   counter (14 for multiply and divide, acc for a nonzero word shifted by less than 14)
// flow: one word at a time; the next is accepted once the result is loaded
// reset: asynchronous active low, clears accumulator, state and output valid
`include "sign_magnitude_accumulator_alu_unit_defines.svh"

module sign_magnitude_accumulator_alu_unit
  import sma_pkg::*;
#(
  parameter int unsigned ADDRESS_WIDTH = AddrWidthDef,
  localparam int unsigned SW = ((WordW + ADDRESS_WIDTH + 7) / 8) * 8,
  localparam int unsigned OW = ((WordW + 1 + ADDRESS_WIDTH + MagW + StatW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // operand_word, operand_address
  input  logic [SW-1:0]    s_axis_tdata,
  // kind
  input  logic [KindW-1:0] s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // acc_value, mem_write, mem_write_address, mem_write_data, status
  output logic [OW-1:0]    m_axis_tdata
);

  localparam int unsigned PW = WordW + 1 + ADDRESS_WIDTH + MagW + StatW;

  sma_state_e               state_q, state_d;
  sma_op_e                  op_q, op_d;
  logic [WordW-1:0]         acc_q, acc_d;
  logic [MagW+1:0]          a_q, a_d;
  logic [MagW-1:0]          b_q, b_d;
  logic [MagW-1:0]          d_q, d_d;
  logic                     sgn_q, sgn_d;
  logic                     wsgn_q, wsgn_d;
  logic                     ovf_q, ovf_d;
  logic [ADDRESS_WIDTH-1:0] addr_q, addr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     m_valid_q, m_valid_d;
  logic [OW-1:0]            m_data_q, m_data_d;
  logic                     load;

  logic [WordW-1:0]         in_word;
  logic [ADDRESS_WIDTH-1:0] in_addr;
  logic                     acc_big;

  logic [MagW+1:0]          mul_t;
  logic [MagW:0]            div_r;
  logic                     div_ge;

  logic                     sb_eff;
  logic [MagW:0]            as_sum;
  logic                     as_ge;
  logic [MagW-1:0]          as_diff;
  logic [MagW:0]            as_mag;
  logic                     as_sgn;

  logic [WordW-1:0]         res_acc;
  sma_status_e              res_stat;
  logic                     res_wr;

  assign in_word = s_axis_tdata[WordW-1:0];
  assign in_addr = s_axis_tdata[WordW+ADDRESS_WIDTH-1:WordW];
  assign acc_big = (acc_q[WordW-1:4] != '0) || (acc_q[3:0] >= 4'(MagW));

  // one bit per step for each serial op
  assign mul_t  = {a_q[MagW:0], 1'b0} + {2'b00, (b_q[MagW-1] ? d_q : '0)};
  assign div_r  = {a_q[MagW-1:0], b_q[MagW-1]};
  assign div_ge = div_r >= {1'b0, d_q};

  // sign-magnitude add and subtract
  always_comb begin
    sb_eff  = wsgn_q ^ (op_q == OP_SUB);
    as_sum  = {1'b0, acc_q[MagW-1:0]} + {1'b0, d_q};
    as_ge   = acc_q[MagW-1:0] >= d_q;
    as_diff = as_ge ? (acc_q[MagW-1:0] - d_q) : (d_q - acc_q[MagW-1:0]);
    if (acc_q[MagW] == sb_eff) begin
      as_mag = as_sum;
      as_sgn = acc_q[MagW];
    end else begin
      as_mag = {1'b0, as_diff};
      as_sgn = as_ge ? acc_q[MagW] : sb_eff;
    end
    if (as_mag == '0) begin
      as_sgn = 1'b0;
    end
  end

  always_comb begin
    res_acc  = acc_q;
    res_stat = STAT_OK;
    res_wr   = 1'b0;
    case (op_q)
      OP_ADD, OP_SUB: begin
        if (as_mag[MagW]) begin
          res_stat = STAT_OVF;
        end else begin
          res_acc = {as_sgn, as_mag[MagW-1:0]};
        end
      end
      OP_DIV: begin
        if (d_q == '0) begin
          res_stat = STAT_DIV0;
        end else begin
          res_acc = {sgn_q, b_q};
        end
      end
      OP_MUL: begin
        if (ovf_q) begin
          res_stat = STAT_OVF;
        end else begin
          res_acc = {sgn_q, a_q[MagW-1:0]};
        end
      end
      OP_SHL: begin
        if (ovf_q) begin
          res_stat = STAT_OVF;
        end else begin
          res_wr = 1'b1;
        end
      end
      default: begin
        res_stat = STAT_BADOP;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    acc_d     = acc_q;
    a_d       = a_q;
    b_d       = b_q;
    d_d       = d_q;
    sgn_d     = sgn_q;
    wsgn_d    = wsgn_q;
    ovf_d     = ovf_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    load      = 1'b0;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          addr_d = in_addr;
          sgn_d  = acc_q[MagW] ^ in_word[MagW];
          wsgn_d = in_word[MagW];
          ovf_d  = 1'b0;
          cnt_d  = '0;
          a_d    = '0;
          b_d    = acc_q[MagW-1:0];
          d_d    = in_word[MagW-1:0];
          unique case (s_axis_tuser)
            KIND_ADD: op_d = OP_ADD;
            KIND_SUB: op_d = OP_SUB;
            KIND_DIV: begin
              op_d = OP_DIV;
              if (in_word[MagW-1:0] != '0) begin
                cnt_d = CntW'(MagW);
              end
            end
            KIND_MUL: begin
              op_d = OP_MUL;
              b_d  = in_word[MagW-1:0];
              d_d  = acc_q[MagW-1:0];
              cnt_d = CntW'(MagW);
            end
            KIND_SHL: begin
              op_d = OP_SHL;
              a_d  = {1'b0, in_word};
              if (in_word != '0) begin
                ovf_d = acc_big || in_word[MagW];
                if (!acc_big) begin
                  cnt_d = acc_q[CntW-1:0];
                end
              end
            end
            default: op_d = OP_BAD;
          endcase
          state_d = (cnt_d == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        case (op_q)
          OP_MUL: begin
            if (!ovf_q) begin
              a_d   = mul_t;
              ovf_d = mul_t[MagW+1:MagW] != '0;
            end
            b_d = {b_q[MagW-2:0], 1'b0};
          end
          OP_DIV: begin
            a_d = div_ge ? {1'b0, div_r - {1'b0, d_q}} : {1'b0, div_r};
            b_d = {b_q[MagW-2:0], div_ge};
          end
          default: begin
            ovf_d = ovf_q | a_q[MagW-1];
            a_d   = {a_q[MagW:0], 1'b0};
          end
        endcase
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          load    = 1'b1;
          acc_d   = res_acc;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (load) begin
      m_valid_d = 1'b1;
      m_data_d  = OW'({res_stat,
                       (res_wr ? a_q[MagW-1:0] : {MagW{1'b0}}),
                       (res_wr ? addr_q : {ADDRESS_WIDTH{1'b0}}),
                       res_wr,
                       res_acc});
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    d_q      <= d_d;
    sgn_q    <= sgn_d;
    wsgn_q   <= wsgn_d;
    ovf_q    <= ovf_d;
    addr_q   <= addr_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SMA_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, state_q != S_IDLE)
  `SMA_ASSERT_IMP(a_run_cnt, state_q == S_RUN, cnt_q != '0)
  `SMA_ASSERT_NEXT(a_acc_hold, !load, $stable(acc_q))
  `SMA_ASSERT_IMP(a_wr_ok, load && res_wr, res_stat == STAT_OK && PW <= OW)

endmodule
